FILE: design/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg: shared definitions for the bitmap slot allocator
// Request codes, field widths and the search result record.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

   // widths fixed by the beat format
   localparam int POS_W  = 6;
   localparam int REQ_W  = 3;
   localparam int DATA_W = 64;

   // default number of bitmap flops
   localparam int MAP_WIDTH_DEF = 64;

   // request codes
   localparam logic [REQ_W-1:0] REQ_SET       = 3'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd1;
   localparam logic [REQ_W-1:0] REQ_TEST      = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FIND_FREE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_FIND_SET  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd5;

   // outcome of a first-match search
   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
   } bsa_find_type;

endpackage

`default_nettype wire

FILE: design/bsa_search.sv
// ----------------------------------------------------------------------------
// bsa_search: first-match search over the occupancy bitmap
// Finds the lowest free or set slot in the window [start, length).
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_search #(
   parameter int MAP_WIDTH = bsa_pkg::MAP_WIDTH_DEF
) (
   input  wire logic [MAP_WIDTH-1:0]     occ,
   input  wire logic [bsa_pkg::POS_W-1:0] search_base,
   input  wire logic [bsa_pkg::POS_W-1:0] map_len,
   input  wire logic                     find_set,
   output bsa_pkg::bsa_find_type         find,
   output logic      [MAP_WIDTH-1:0]     find_mask
);

   logic [MAP_WIDTH-1:0]      window;
   logic [MAP_WIDTH-1:0]      cand;
   logic [bsa_pkg::POS_W-1:0] enc_pos;

   // slots from the start position up to the map length
   always_comb begin
      for (int i = 0; i < MAP_WIDTH; i++) begin
         window[i] = (bsa_pkg::POS_W'(i) >= search_base) && (bsa_pkg::POS_W'(i) < map_len);
      end
   end

   // candidates, then isolate the lowest one
   assign cand      = (find_set ? occ : ~occ) & window;
   assign find_mask = cand & (~cand + MAP_WIDTH'(1));

   // encode the one-hot mask into a position
   always_comb begin
      enc_pos = '0;
      for (int i = 0; i < MAP_WIDTH; i++) begin
         if (find_mask[i]) begin
            enc_pos = enc_pos | bsa_pkg::POS_W'(i);
         end
      end
   end

   assign find.hit = |cand;
   assign find.pos = find.hit ? enc_pos : map_len;

endmodule

`default_nettype wire

FILE: design/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator: occupancy bitmap with free-slot count
// Set, clear, test, clear-all and first-free / first-set search requests.
// ----------------------------------------------------------------------------
//
//  port group  dir   handshake           contents
//  req_*       in    req_valid/req_stall req_type, req_slot_pos
//  rsp_*       out   rsp_valid/rsp_stall bit_before, search_hit, hit_pos,
//                                        hit_mask, free_slots, map_image,
//                                        range_error
//  csr_*       in    csr_wr_en           csr_wr_data = map_length
//
//  one beat per cycle unless rsp stalls; req passes input and result registers
//  the bitmap and free count update in the stage that reads them
//  reset: map empty, length and free count at MAP_WIDTH-1
//  a stalled rsp holds its beat; req stalls only while the input register
//  is full and its beat cannot move into the result register
//  a length write clears the map and loads the free count
//
`default_nettype none

module bitmap_slot_allocator #(
   parameter int MAP_WIDTH = bsa_pkg::MAP_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [bsa_pkg::REQ_W-1:0]   req_type,
   input  wire logic [bsa_pkg::POS_W-1:0]   req_slot_pos,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_bit_before,
   output logic                             rsp_search_hit,
   output logic      [bsa_pkg::POS_W-1:0]   rsp_hit_pos,
   output logic      [bsa_pkg::DATA_W-1:0]  rsp_hit_mask,
   output logic      [bsa_pkg::POS_W-1:0]   rsp_free_slots,
   output logic      [bsa_pkg::DATA_W-1:0]  rsp_map_image,
   output logic                             rsp_range_error,
   // configuration
   input  wire logic                        csr_wr_en,
   input  wire logic [bsa_pkg::POS_W-1:0]   csr_wr_data
);

   localparam logic [bsa_pkg::POS_W-1:0] LEN_MAX = bsa_pkg::POS_W'(MAP_WIDTH - 1);

   // state
   logic [MAP_WIDTH-1:0]      occ_ff, occ_in;
   logic [bsa_pkg::POS_W-1:0] free_ff, free_in;
   logic [bsa_pkg::POS_W-1:0] len_ff;
   logic [bsa_pkg::POS_W-1:0] len_wr;

   // input register
   logic                      stg_valid_ff;
   logic [bsa_pkg::REQ_W-1:0] stg_type_ff;
   logic [bsa_pkg::POS_W-1:0] stg_pos_ff;

   // result register
   logic                       rsp_valid_ff;
   logic                       bit_before_ff, bit_before_in;
   logic                       hit_ff, hit_in;
   logic [bsa_pkg::POS_W-1:0]  hit_pos_ff, hit_pos_in;
   logic [bsa_pkg::DATA_W-1:0] mask_ff, mask_in;
   logic [bsa_pkg::POS_W-1:0]  free_out_ff;
   logic [bsa_pkg::DATA_W-1:0] map_ff;
   logic                       err_ff, err_in;

   logic                  advance;
   logic                  req_take;
   logic [MAP_WIDTH-1:0]  sel;
   logic                  addr_bit;
   logic                  is_find;
   logic                  out_of_range;
   bsa_pkg::bsa_find_type find;
   logic [MAP_WIDTH-1:0]  find_mask;

   // handshake: stage moves on when the result register is free or draining
   assign advance   = stg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stg_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // length write saturates to MAP_WIDTH-1
   assign len_wr = (csr_wr_data > LEN_MAX) ? LEN_MAX : csr_wr_data;

   // one-hot select of the addressed slot
   always_comb begin
      for (int i = 0; i < MAP_WIDTH; i++) begin
         sel[i] = (stg_pos_ff == bsa_pkg::POS_W'(i));
      end
   end

   assign addr_bit     = |(occ_ff & sel);
   assign is_find      = (stg_type_ff == bsa_pkg::REQ_FIND_FREE) ||
                         (stg_type_ff == bsa_pkg::REQ_FIND_SET);
   assign out_of_range = (stg_type_ff <= bsa_pkg::REQ_FIND_SET) && (stg_pos_ff >= len_ff);

   bsa_search #(
      .MAP_WIDTH (MAP_WIDTH)
   ) u_search (
      .occ         (occ_ff),
      .search_base (stg_pos_ff),
      .map_len     (len_ff),
      .find_set    (stg_type_ff == bsa_pkg::REQ_FIND_SET),
      .find        (find),
      .find_mask   (find_mask)
   );

   // request decode, next map and result fields
   always_comb begin
      occ_in        = occ_ff;
      free_in       = free_ff;
      bit_before_in = 1'b0;
      hit_in        = 1'b0;
      hit_pos_in    = '0;
      mask_in       = '0;
      err_in        = 1'b0;
      priority if (out_of_range) begin
         err_in = 1'b1;
         if (is_find) begin
            hit_pos_in = len_ff;
         end
      end else begin
         unique case (stg_type_ff)
            bsa_pkg::REQ_SET: begin
               bit_before_in = addr_bit;
               mask_in       = bsa_pkg::DATA_W'(sel);
               if (!addr_bit) begin
                  occ_in  = occ_ff | sel;
                  free_in = free_ff - 1'b1;
               end
            end
            bsa_pkg::REQ_CLEAR: begin
               bit_before_in = addr_bit;
               mask_in       = bsa_pkg::DATA_W'(sel);
               if (addr_bit) begin
                  occ_in  = occ_ff & ~sel;
                  free_in = free_ff + 1'b1;
               end
            end
            bsa_pkg::REQ_TEST: begin
               bit_before_in = addr_bit;
               mask_in       = bsa_pkg::DATA_W'(sel);
            end
            bsa_pkg::REQ_FIND_FREE, bsa_pkg::REQ_FIND_SET: begin
               hit_in     = find.hit;
               hit_pos_in = find.pos;
               mask_in    = bsa_pkg::DATA_W'(find_mask);
            end
            bsa_pkg::REQ_CLEAR_ALL: begin
               occ_in  = '0;
               free_in = len_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
         free_ff      <= LEN_MAX;
         len_ff       <= LEN_MAX;
      end else begin
         if (req_take) begin
            stg_valid_ff <= 1'b1;
         end else if (advance) begin
            stg_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            len_ff  <= len_wr;
            occ_ff  <= '0;
            free_ff <= len_wr;
         end else if (advance) begin
            occ_ff  <= occ_in;
            free_ff <= free_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_type_ff <= req_type;
         stg_pos_ff  <= req_slot_pos;
      end
      if (advance) begin
         bit_before_ff <= bit_before_in;
         hit_ff        <= hit_in;
         hit_pos_ff    <= hit_pos_in;
         mask_ff       <= mask_in;
         free_out_ff   <= free_in;
         map_ff        <= bsa_pkg::DATA_W'(occ_in);
         err_ff        <= err_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bit_before  = bit_before_ff;
   assign rsp_search_hit  = hit_ff;
   assign rsp_hit_pos     = hit_pos_ff;
   assign rsp_hit_mask    = mask_ff;
   assign rsp_free_slots  = free_out_ff;
   assign rsp_map_image   = map_ff;
   assign rsp_range_error = err_ff;

   // free count always matches the clear slots below the length
   a_free_count: assert property (@(posedge clock) disable iff (reset)
      ($countones(occ_ff) + int'(free_ff)) == int'(len_ff))
      else $error("free count out of step with bitmap");

   // no slot at or above the length is ever occupied
   a_occ_in_range: assert property (@(posedge clock) disable iff (reset)
      (occ_ff >> len_ff) == '0)
      else $error("occupied slot beyond map length");

   // a found slot comes with exactly one mask bit at its position
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_search_hit) |-> (rsp_hit_mask == (64'd1 << rsp_hit_pos)))
      else $error("search hit mask does not match position");

   // a range error leaves no mask and no hit
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_hit_mask == '0 && !rsp_search_hit))
      else $error("range error beat carries a mask");

   // a beat leaving the stage always lands in the result register
   a_stage_drain: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("stage advanced without a result");

endmodule

`default_nettype wire
